>>> src/rdcs_pkg.sv
// Package for the row density change splitter.
// Holds field widths, register codes, reset values and the sequencer state type.
// No dependencies.
package rdcs_pkg;

  localparam int IN_W      = 32;  // row_count_nnz field
  localparam int ROW_W     = 32;  // boundary_row field and row index
  localparam int SUM_W     = 36;  // saturating window sum
  localparam int RATE_W    = 16;  // split_rate, Q8.8
  localparam int WIN_W     = 5;   // window_size register
  localparam int FRAC_BITS = 8;   // fraction bits of split_rate
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_RATE  = 1'b1;

  localparam logic [WIN_W-1:0]  WIN_RESET  = 5'd4;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd512;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL_CN,
    ST_MUL_CNR,
    ST_MUL_SR,
    ST_DECIDE,
    ST_EMIT_SPLIT,
    ST_EMIT_FIN
  } state_t;

endpackage

>>> src/row_density_change_splitter_unit.sv
// Row density change splitter: top level with its sequencer and shared multiplier.
// Depends on rdcs_pkg and rdcs_ram (history ring).
//
// Usage: each input beat (s_tdata = row nonzero count, s_tlast = last row of the
// matrix) is compared with the average of the counts held in its window. A row
// whose count falls below avg/rate or rises above avg*rate starts a new block and
// produces an output beat carrying its row index (m_tuser = 0). The last row adds
// a beat with the total row count (m_tuser = 1). m_tlast marks the last beat that
// an input row causes. A row that neither splits nor ends the matrix gives no beat.
// For each row the sum reads n ring entries, where n (1 to window_size-1, clipped
// to [1, MAX_WINDOW-1]) is the number of held counts; it reads one ring entry
// per cycle through the single RAM read port, then the one multiplier (16-bit b input)
// runs three passes (count*n, *rate, sum*rate). s_tready is high only between rows.
// Output goes through one register; a stalled receiver holds the sequencer in its
// emit step, while a row may still be accepted with the last beat waiting.
// Reset (synchronous, rst high) empties the window to zero padding, clears the
// row index, and sets window_size = 4 and split_rate = 2.0; after the last row
// the window and row index return to that state, registers keep their values.
// Configuration (cfg_we, cfg_index, cfg_data) is written only between rows.
module row_density_change_splitter_unit #(
  parameter int MAX_WINDOW  = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // input rows
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rdcs_pkg::IN_W-1:0]         s_tdata,   // [31:0] row_count_nnz
  input  logic                              s_tlast,   // final_row
  // output boundaries
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rdcs_pkg::ROW_W-1:0]        m_tdata,   // [31:0] boundary_row
  output logic                              m_tuser,   // [0] is_terminal
  output logic                              m_tlast,   // run_end
  // configuration
  input  logic                              cfg_we,
  input  logic [rdcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rdcs_pkg::RATE_W-1:0]       cfg_data
);

  import rdcs_pkg::*;

  localparam int HW         = $clog2(MAX_WINDOW);
  localparam int RING_DEPTH = MAX_WINDOW - 1;
  localparam int PW         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CN_W       = COUNT_WIDTH + HW;
  localparam int MUL_A_W    = (CN_W > SUM_W) ? CN_W : SUM_W;
  localparam int MUL_P_W    = MUL_A_W + RATE_W;

  // effective window size minus one, clipped to [1, MAX_WINDOW-1]
  function automatic logic [HW-1:0] wm1_of(input logic [WIN_W-1:0] w);
    logic [HW-1:0] r;
    if (w < WIN_W'(2)) begin
      r = HW'(1);
    end else if (32'(w) > MAX_WINDOW) begin
      r = HW'(MAX_WINDOW - 1);
    end else begin
      r = HW'(w - WIN_W'(1));
    end
    return r;
  endfunction

  state_t state, state_next;

  // configuration
  logic [WIN_W-1:0]  window_size;
  logic [RATE_W-1:0] split_rate;

  // stream state
  logic [PW-1:0]         ring_pointer;
  logic [RING_DEPTH-1:0] ring_valid;
  logic [HW-1:0]         held_count;
  logic [ROW_W-1:0]      row_index;

  // per-row work registers
  logic [COUNT_WIDTH-1:0] cur_count;
  logic                   cur_final;
  logic [HW-1:0]          n_q;
  logic [HW-1:0]          k;
  logic [PW-1:0]          rd_ptr;
  logic                   rd_pend;
  logic                   rd_valid;
  logic [SUM_W-1:0]       sum_acc;
  logic [CN_W-1:0]        cn;
  logic [CN_W+RATE_W-1:0] cnr;
  logic [SUM_W+RATE_W-1:0] sr;

  // ring RAM
  logic [COUNT_WIDTH-1:0] ring_rdata;

  // sequencer outputs
  logic               accept;
  logic               out_free;
  logic               out_load;
  logic [ROW_W-1:0]   out_row;
  logic               out_term;
  logic               out_last;
  logic [MUL_A_W-1:0] mul_a;
  logic [RATE_W-1:0]  mul_b;
  logic [MUL_P_W-1:0] mul_p;

  // combinational helpers
  logic [HW-1:0]     wm1;
  logic [HW-1:0]     held_min;
  logic [HW-1:0]     n_start;
  logic [HW:0]       n_inc;
  logic [HW-1:0]     held_grow;
  logic [SUM_W:0]    sum_add;
  logic [MUL_P_W-1:0] below_lhs, below_rhs, above_lhs, above_rhs;
  logic              split;

  assign wm1      = wm1_of(window_size);
  assign held_min = (held_count < wm1) ? held_count : wm1;
  assign n_start  = (held_min == '0) ? HW'(1) : held_min;
  assign n_inc    = {1'b0, n_q} + (HW+1)'(1);
  assign held_grow = (n_inc < {1'b0, wm1}) ? n_inc[HW-1:0] : wm1;

  // unused padding slots read as zero
  assign sum_add = {1'b0, sum_acc}
                 + (SUM_W+1)'(rd_valid ? ring_rdata : '0);

  assign mul_p = mul_a * mul_b;

  // c*n*R < S*256 or c*n*256 > S*R
  assign below_lhs = MUL_P_W'(cnr);
  assign below_rhs = MUL_P_W'(sum_acc) << FRAC_BITS;
  assign above_lhs = MUL_P_W'(cn) << FRAC_BITS;
  assign above_rhs = MUL_P_W'(sr);
  assign split     = (below_lhs < below_rhs) || (above_lhs > above_rhs);

  assign out_free = !m_tvalid || m_tready;

  rdcs_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_DECIDE),
    .waddr (ring_pointer),
    .wdata (cur_count),
    .raddr (rd_ptr),
    .rdata (ring_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (s_tvalid) state_next = ST_SUM;
      ST_SUM:        if (k == n_q) state_next = ST_MUL_CN;
      ST_MUL_CN:     state_next = ST_MUL_CNR;
      ST_MUL_CNR:    state_next = ST_MUL_SR;
      ST_MUL_SR:     state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (split) begin
          state_next = ST_EMIT_SPLIT;
        end else if (cur_final) begin
          state_next = ST_EMIT_FIN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_SPLIT: if (out_free) state_next = cur_final ? ST_EMIT_FIN : ST_IDLE;
      ST_EMIT_FIN:   if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    out_row  = row_index;
    out_term = 1'b0;
    out_last = 1'b1;
    mul_a    = MUL_A_W'(cur_count);
    mul_b    = RATE_W'(n_q);
    unique case (state)
      ST_IDLE:    s_tready = 1'b1;
      ST_MUL_CN: begin
        mul_a = MUL_A_W'(cur_count);
        mul_b = RATE_W'(n_q);
      end
      ST_MUL_CNR: begin
        mul_a = MUL_A_W'(cn);
        mul_b = split_rate;
      end
      ST_MUL_SR: begin
        mul_a = MUL_A_W'(sum_acc);
        mul_b = split_rate;
      end
      ST_EMIT_SPLIT: begin
        out_load = out_free;
        out_row  = row_index;
        out_last = !cur_final;
      end
      ST_EMIT_FIN: begin
        out_load = out_free;
        out_row  = row_index + ROW_W'(1);
        out_term = 1'b1;
      end
      default: ;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // control and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_size  <= WIN_RESET;
      split_rate   <= RATE_RESET;
      ring_pointer <= '0;
      ring_valid   <= '0;
      held_count   <= wm1_of(WIN_RESET);
      row_index    <= '0;
      m_tvalid     <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      state <= state_next;

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      rd_pend <= (state == ST_SUM) && (k != n_q);

      unique case (state)
        ST_IDLE: begin
          if (cfg_we) begin
            unique case (cfg_index)
              REG_WINDOW_SIZE: begin
                window_size <= cfg_data[WIN_W-1:0];
                if (row_index == '0) begin
                  held_count <= wm1_of(cfg_data[WIN_W-1:0]);
                end
              end
              REG_SPLIT_RATE: split_rate <= cfg_data;
              default: ;
            endcase
          end
        end
        ST_DECIDE: begin
          ring_valid[ring_pointer] <= 1'b1;
          ring_pointer <= (ring_pointer == PW'(RING_DEPTH - 1)) ? '0
                                                                : ring_pointer + PW'(1);
          held_count   <= split ? HW'(1) : held_grow;
          if (!split && !cur_final) begin
            row_index <= row_index + ROW_W'(1);
          end
        end
        ST_EMIT_SPLIT: begin
          if (out_free && !cur_final) begin
            row_index <= row_index + ROW_W'(1);
          end
        end
        ST_EMIT_FIN: begin
          if (out_free) begin
            ring_pointer <= '0;
            ring_valid   <= '0;
            held_count   <= wm1;
            row_index    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // per-row datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_count <= s_tdata[COUNT_WIDTH-1:0];
      cur_final <= s_tlast;
      n_q       <= n_start;
      k         <= '0;
      sum_acc   <= '0;
      rd_ptr    <= (ring_pointer == '0) ? PW'(RING_DEPTH - 1) : ring_pointer - PW'(1);
    end
    if (state == ST_SUM) begin
      // walk back from the newest count, one RAM read per cycle
      if (k != n_q) begin
        k      <= k + HW'(1);
        rd_ptr <= (rd_ptr == '0) ? PW'(RING_DEPTH - 1) : rd_ptr - PW'(1);
      end
    end
    rd_valid <= ring_valid[rd_ptr];
    if (rd_pend) begin
      sum_acc <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    end
    if (state == ST_MUL_CN)  cn  <= mul_p[CN_W-1:0];
    if (state == ST_MUL_CNR) cnr <= mul_p[CN_W+RATE_W-1:0];
    if (state == ST_MUL_SR)  sr  <= mul_p[SUM_W+RATE_W-1:0];
    if (out_load) begin
      m_tdata <= out_row;
      m_tuser <= out_term;
      m_tlast <= out_last;
    end
  end

  // assertions
  a_held_nonzero: assert property (@(posedge clk) disable iff (rst)
    held_count != '0)
    else $error("held count reached zero");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM |-> k <= n_q)
    else $error("window sum read past held count");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    32'(ring_pointer) < RING_DEPTH)
    else $error("ring pointer out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !out_load)
    else $error("output beat overwritten while stalled");

  a_term_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("terminal beat without run end");

  a_sum_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL_CN |-> !rd_pend)
    else $error("multiply started before sum complete");

endmodule

>>> src/rdcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rdcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 15
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
